FILE: src/bgpf_pkg.sv
// ----------------------------------------------------------------------------
// bgpf_pkg
// Shared types and codes for the per-port BGP session state machine.
// ----------------------------------------------------------------------------
package bgpf_pkg;

	localparam int DEF_NUM_PORTS = 8;
	localparam int MAX_PORTS     = 16;
	localparam int PIDX_W        = 4;   // holds any port index below MAX_PORTS
	localparam int TMR_W         = 16;
	localparam int MAX_RES       = 6;   // results per port and item
	localparam int RIDX_W        = 3;

	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_START = 2'd1;
	localparam logic [1:0] FN_MSG   = 2'd2;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_CONNECT  = 3'd1;
	localparam logic [2:0] ST_ACTIVE   = 3'd2;
	localparam logic [2:0] ST_OSENT    = 3'd3;
	localparam logic [2:0] ST_OCONFIRM = 3'd4;
	localparam logic [2:0] ST_ESTAB    = 3'd5;

	localparam logic [2:0] RX_SYN       = 3'd0;
	localparam logic [2:0] RX_ACK       = 3'd1;
	localparam logic [2:0] RX_SYNACK    = 3'd2;
	localparam logic [2:0] RX_OPEN      = 3'd3;
	localparam logic [2:0] RX_UPDATE    = 3'd4;
	localparam logic [2:0] RX_KEEPALIVE = 3'd5;

	localparam logic [2:0] TX_SYN       = 3'd0;
	localparam logic [2:0] TX_SYNACK    = 3'd1;
	localparam logic [2:0] TX_ACK       = 3'd2;
	localparam logic [2:0] TX_OPEN      = 3'd3;
	localparam logic [2:0] TX_KEEPALIVE = 3'd4;

	localparam logic [1:0] KIND_REPORT = 2'd0;
	localparam logic [1:0] KIND_SEND   = 2'd1;
	localparam logic [1:0] KIND_UPDATE = 2'd2;

	localparam logic [1:0] REG_HOLD    = 2'd0;
	localparam logic [1:0] REG_RETRY   = 2'd1;
	localparam logic [1:0] REG_CONNECT = 2'd2;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EVAL,
		CS_EMIT,
		CS_FLUSH
	} ctl_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] from_state;
		logic [2:0] to_state;
		logic [2:0] sent_message;
	} res_t;

	typedef struct packed {
		logic              load;   // capture the input word
		logic              eval;   // apply one port update, fill result list
		logic              emit;   // push list entry idx
		logic              flush;  // release held word with last set
		logic [PIDX_W-1:0] port;
		logic [RIDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [2:0]        iface;
		logic [RIDX_W-1:0] count;
	} sts_t;

	function automatic logic [TMR_W-1:0] dec_sat(input logic [TMR_W-1:0] v);
		dec_sat = (v != '0) ? v - 1'b1 : v;
	endfunction

endpackage

FILE: src/bgpf_ctrl.sv
// ----------------------------------------------------------------------------
// bgpf_ctrl
// Sequencer: walks ports for a tick, steps through each port's result list.
// ----------------------------------------------------------------------------
module bgpf_ctrl import bgpf_pkg::*; #(
	parameter int NUM_PORTS = DEF_NUM_PORTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic [PIDX_W-1:0] port_q, port_d;
	logic [RIDX_W-1:0] idx_q, idx_d;
	logic              func_tick;

	assign func_tick = (sts.func == FN_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			port_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			port_q  <= port_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		port_d    = port_q;
		idx_d     = idx_q;
		cmd       = '0;
		cmd.port  = port_q;
		cmd.idx   = idx_q;
		busy      = (state_q != CS_IDLE);
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = CS_EVAL;
				end
			end
			CS_EVAL: begin
				// pick the port on the first pass
				if (func_tick) begin
					cmd.eval = 1'b1;
					state_d  = CS_EMIT;
				end else if ((sts.func == FN_START || sts.func == FN_MSG) &&
						({{(32-3){1'b0}}, sts.iface} < NUM_PORTS)) begin
					cmd.port = PIDX_W'(sts.iface);
					port_d   = PIDX_W'(sts.iface);
					cmd.eval = 1'b1;
					state_d  = CS_EMIT;
				end else begin
					state_d = CS_FLUSH;
				end
				idx_d = '0;
			end
			CS_EMIT: begin
				if (idx_q < sts.count) begin
					cmd.emit = 1'b1;
					idx_d    = idx_q + 1'b1;
				end else if (func_tick && ({{(32-PIDX_W){1'b0}}, port_q} < NUM_PORTS - 1)) begin
					port_d   = port_q + 1'b1;
					cmd.port = port_q + 1'b1;
					cmd.eval = 1'b1;
					idx_d    = '0;
				end else begin
					state_d = CS_FLUSH;
				end
			end
			CS_FLUSH: begin
				cmd.flush = 1'b1;
				port_d    = '0;
				state_d   = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

endmodule

FILE: src/bgpf_dp.sv
// ----------------------------------------------------------------------------
// bgpf_dp
// Per-port session state, timers, result list and output register.
// ----------------------------------------------------------------------------
module bgpf_dp import bgpf_pkg::*; #(
	parameter int NUM_PORTS = DEF_NUM_PORTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [1:0]       func,
	input  logic [2:0]       iface,
	input  logic [2:0]       message,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [TMR_W-1:0] cfg_data,
	output sts_t             sts,
	output logic             strobe,
	output logic [2:0]       port,
	output logic [1:0]       kind,
	output logic [2:0]       from_state,
	output logic [2:0]       to_state,
	output logic [2:0]       sent_message,
	output logic             last
);

	localparam int IW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	logic [TMR_W-1:0] hold_rl_q, retry_rl_q, conn_rl_q;

	logic [2:0]       sess_q [NUM_PORTS];
	logic [TMR_W-1:0] hold_q [NUM_PORTS];
	logic [TMR_W-1:0] retry_q [NUM_PORTS];
	logic [TMR_W-1:0] conn_q [NUM_PORTS];
	logic             syn_q [NUM_PORTS];
	logic             synack_q [NUM_PORTS];

	logic [1:0] func_q;
	logic [2:0] iface_q, msg_q;

	res_t             list_q [MAX_RES];
	logic [RIDX_W-1:0] cnt_q;

	res_t       pend_q;
	logic [2:0] pend_port_q;
	logic       pend_v_q;

	logic [IW-1:0] pi;
	logic [2:0]       s, s_o;
	logic [TMR_W-1:0] h, r, c;
	logic             sf, saf, hs;
	res_t             lst [MAX_RES];
	logic [RIDX_W-1:0] n;

	assign pi  = cmd.port[IW-1:0];
	assign sts = '{func: func_q, iface: iface_q, count: cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_rl_q  <= TMR_W'(90);
			retry_rl_q <= TMR_W'(120);
			conn_rl_q  <= TMR_W'(30);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOLD:    hold_rl_q  <= cfg_data;
				REG_RETRY:   retry_rl_q <= cfg_data;
				REG_CONNECT: conn_rl_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// one port update, results collected in order
	always_comb begin
		s   = sess_q[pi];
		s_o = s;
		h   = hold_q[pi];
		r   = retry_q[pi];
		c   = conn_q[pi];
		sf  = syn_q[pi];
		saf = synack_q[pi];
		hs  = (s == ST_CONNECT || s == ST_ACTIVE);
		n   = '0;
		for (int i = 0; i < MAX_RES; i++) lst[i] = '0;
		case (func_q)
			FN_TICK: begin
				if (s == ST_ESTAB || s == ST_OCONFIRM || s == ST_OSENT) begin
					h = dec_sat(h);
					if (h == '0) begin
						c = conn_rl_q;
						r = retry_rl_q;
						h = hold_rl_q;
						lst[n] = '{KIND_REPORT, s, ST_IDLE, TX_SYN};
						lst[n].sent_message = '0;
						n = n + 1'b1;
						lst[n] = '{KIND_REPORT, ST_IDLE, ST_CONNECT, 3'd0};
						n = n + 1'b1;
						lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_SYN};
						n = n + 1'b1;
						s_o = ST_CONNECT;
						sf  = 1'b1;
					end
				end
				if (s_o == ST_CONNECT) begin
					r = dec_sat(r);
					if (r == '0) begin
						c   = conn_rl_q;
						s_o = ST_ACTIVE;
						lst[n] = '{KIND_REPORT, ST_CONNECT, ST_ACTIVE, 3'd0};
						n = n + 1'b1;
					end else begin
						c = dec_sat(c);
						if (c == '0) begin
							c = conn_rl_q;
							r = retry_rl_q;
							lst[n] = '{KIND_REPORT, ST_CONNECT, ST_IDLE, 3'd0};
							n = n + 1'b1;
							lst[n] = '{KIND_REPORT, ST_IDLE, ST_CONNECT, 3'd0};
							n = n + 1'b1;
							lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_SYN};
							n = n + 1'b1;
							sf = 1'b1;
						end
					end
				end else if (s_o == ST_ACTIVE) begin
					c = dec_sat(c);
					if (c == '0) begin
						c   = conn_rl_q;
						r   = retry_rl_q;
						s_o = ST_CONNECT;
						lst[n] = '{KIND_REPORT, ST_ACTIVE, ST_CONNECT, 3'd0};
						n = n + 1'b1;
						lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_SYN};
						n = n + 1'b1;
						sf = 1'b1;
					end
				end
			end
			FN_START: begin
				if (s == ST_IDLE) begin
					s_o = ST_CONNECT;
					r   = retry_rl_q;
					c   = conn_rl_q;
					sf  = 1'b1;
					lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_SYN};
					n = n + 1'b1;
					lst[n] = '{KIND_REPORT, ST_IDLE, ST_CONNECT, 3'd0};
					n = n + 1'b1;
				end
			end
			FN_MSG: begin
				if (s != ST_IDLE) begin
					case (msg_q)
						RX_SYN: begin
							if (hs) begin
								lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_SYNACK};
								n = n + 1'b1;
								saf = 1'b1;
								r   = retry_rl_q;
							end
						end
						RX_ACK, RX_SYNACK: begin
							if (hs && ((msg_q == RX_ACK && saf) ||
									(msg_q == RX_SYNACK && sf))) begin
								if (msg_q == RX_SYNACK) begin
									lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_ACK};
									n = n + 1'b1;
								end
								lst[n] = '{KIND_REPORT, s, ST_OSENT, 3'd0};
								n = n + 1'b1;
								lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_OPEN};
								n = n + 1'b1;
								r   = retry_rl_q;
								c   = conn_rl_q;
								h   = hold_rl_q;
								sf  = 1'b0;
								saf = 1'b0;
								s_o = ST_OSENT;
							end
						end
						RX_OPEN: begin
							if (s == ST_OSENT) begin
								lst[n] = '{KIND_SEND, 3'd0, 3'd0, TX_KEEPALIVE};
								n = n + 1'b1;
								lst[n] = '{KIND_REPORT, ST_OSENT, ST_OCONFIRM, 3'd0};
								n = n + 1'b1;
								s_o = ST_OCONFIRM;
								h   = hold_rl_q;
							end
						end
						RX_UPDATE: begin
							if (s == ST_ESTAB) begin
								lst[n] = '{KIND_UPDATE, 3'd0, 3'd0, 3'd0};
								n = n + 1'b1;
								h = hold_rl_q;
							end
						end
						RX_KEEPALIVE: begin
							if (s == ST_OCONFIRM || s == ST_ESTAB) begin
								if (s == ST_OCONFIRM) begin
									lst[n] = '{KIND_REPORT, ST_OCONFIRM, ST_ESTAB, 3'd0};
									n = n + 1'b1;
								end
								s_o = ST_ESTAB;
								h   = hold_rl_q;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				sess_q[i]   <= ST_IDLE;
				hold_q[i]   <= '0;
				retry_q[i]  <= '0;
				conn_q[i]   <= '0;
				syn_q[i]    <= 1'b0;
				synack_q[i] <= 1'b0;
			end
			cnt_q <= '0;
		end else if (cmd.eval) begin
			sess_q[pi]   <= s_o;
			hold_q[pi]   <= h;
			retry_q[pi]  <= r;
			conn_q[pi]   <= c;
			syn_q[pi]    <= sf;
			synack_q[pi] <= saf;
			cnt_q        <= n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			iface_q <= iface;
			msg_q   <= message;
		end
		if (cmd.eval) begin
			for (int i = 0; i < MAX_RES; i++) list_q[i] <= lst[i];
		end
	end

	// hold one word back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			if (cmd.emit) begin
				strobe   <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				strobe   <= pend_v_q;
				pend_v_q <= 1'b0;
			end else begin
				strobe <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.flush) begin
			port         <= pend_port_q;
			kind         <= pend_q.kind;
			from_state   <= pend_q.from_state;
			to_state     <= pend_q.to_state;
			sent_message <= pend_q.sent_message;
			last         <= cmd.flush;
		end
		if (cmd.emit) begin
			pend_q      <= list_q[cmd.idx];
			pend_port_q <= cmd.port[2:0];
		end
	end

endmodule

FILE: src/bgp_session_fsm.sv
// ----------------------------------------------------------------------------
// bgp_session_fsm
// Simplified BGP session state machine kept for each port.
// ----------------------------------------------------------------------------
// Use: raise start with func, iface and message while busy is low; the word
// is taken at that edge and busy rises. Results come out one per cycle on
// port/kind/from_state/to_state/sent_message within a port's list (a tick
// pauses for each further port's evaluate step), each marked by strobe for
// one cycle; last is set on the final result of the item. The receiver
// cannot stall, so nothing here waits on the output side.
// Sequence: a start or message is loaded, evaluated for its iface port
// (if below NUM_PORTS), emitted and flushed; a tick walks all ports in
// turn, evaluating each and emitting its results, then flushes.
// Configuration: cfg_we, cfg_index, cfg_data write a reload register. The
// user must write it only while busy is low; the block does not enforce it.
// Reset: all ports go idle with timers and flags cleared; the reload
// registers return to 90, 120 and 30.
// ----------------------------------------------------------------------------
module bgp_session_fsm import bgpf_pkg::*; #(
	parameter int NUM_PORTS = DEF_NUM_PORTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       func,
	input  logic [2:0]       iface,
	input  logic [2:0]       message,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [TMR_W-1:0] cfg_data,
	output logic             strobe,
	output logic [2:0]       port,
	output logic [1:0]       kind,
	output logic [2:0]       from_state,
	output logic [2:0]       to_state,
	output logic [2:0]       sent_message,
	output logic             last
);

	cmd_t cmd;
	sts_t sts;
	logic busy_i;

	assign busy = busy_i;

	bgpf_ctrl #(.NUM_PORTS(NUM_PORTS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy_i),
		.cmd    (cmd)
	);

	bgpf_dp #(.NUM_PORTS(NUM_PORTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.iface        (iface),
		.message      (message),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sts          (sts),
		.strobe       (strobe),
		.port         (port),
		.kind         (kind),
		.from_state   (from_state),
		.to_state     (to_state),
		.sent_message (sent_message),
		.last         (last)
	);

endmodule
